// ===== rtl/edbe_pkg.sv =====
// ----------------------------------------------------------------------------
// edbe_pkg
// Types and constants shared by the encoder detent and button event unit.
// ----------------------------------------------------------------------------
package edbe_pkg;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [CfgIdxWidth-1:0] REG_COUNTS_PER_DETENT = 3'd0;
  localparam logic [CfgIdxWidth-1:0] REG_INVERT_DIRECTION  = 3'd1;
  localparam logic [CfgIdxWidth-1:0] REG_MAX_STEPS         = 3'd2;
  localparam logic [CfgIdxWidth-1:0] REG_DEBOUNCE_MS       = 3'd3;
  localparam logic [CfgIdxWidth-1:0] REG_CLICK_MAX_MS      = 3'd4;
  localparam logic [CfgIdxWidth-1:0] REG_LONG_PRESS_MS     = 3'd5;

  localparam logic [4:0]  RST_COUNTS_PER_DETENT = 5'd4;
  localparam logic        RST_INVERT_DIRECTION  = 1'b0;
  localparam logic [3:0]  RST_MAX_STEPS         = 4'd1;
  localparam logic [15:0] RST_DEBOUNCE_MS       = 16'd30;
  localparam logic [15:0] RST_CLICK_MAX_MS      = 16'd800;
  localparam logic [15:0] RST_LONG_PRESS_MS     = 16'd1000;

  localparam int unsigned DivSteps = 32;
  localparam int unsigned DivCntWidth = 5;

  typedef struct packed {
    logic [31:0] raw_count;
    logic        key_pressed;
    logic [31:0] time_ms;
    logic        take_steps;
    logic        take_click;
    logic        take_long;
  } in_item_t;

  typedef struct packed {
    logic signed [4:0] steps;
    logic              click;
    logic              long_press;
    logic              held;
  } out_item_t;

  typedef struct packed {
    logic [4:0]  counts_per_detent;
    logic        invert_direction;
    logic [3:0]  max_steps_per_take;
    logic [15:0] debounce_ms;
    logic [15:0] click_max_ms;
    logic [15:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic               first;
    logic signed [31:0] delta;
    logic               key_pressed;
    logic [31:0]        time_ms;
    logic               take_steps;
    logic               take_click;
    logic               take_long;
  } poll_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FOLD,
    BK_FIN
  } back_state_e;

endpackage

// ===== rtl/edbe_queue.sv =====
// ----------------------------------------------------------------------------
// edbe_queue
// Short register queue that holds classified polls between front and back.
// ----------------------------------------------------------------------------
module edbe_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  edbe_pkg::poll_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output edbe_pkg::poll_t pop_data_o,
  output logic            empty_o
);
  import edbe_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
  localparam logic [AW:0] FullCnt = (AW + 1)'(DEPTH);

  poll_t         mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [AW:0]   cnt_q, cnt_d;

  assign full_o     = (cnt_q == FullCnt);
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/edbe_front.sv =====
// ----------------------------------------------------------------------------
// edbe_front
// Accepts polls, marks the first one and turns the counter into a delta.
// ----------------------------------------------------------------------------
module edbe_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  edbe_pkg::in_item_t in_data_i,
  output logic               push_o,
  output edbe_pkg::poll_t    push_data_o,
  input  logic               full_i
);
  import edbe_pkg::*;

  logic        primed_q, primed_d;
  logic [31:0] last_count_q, last_count_d;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    push_data_o.first       = !primed_q;
    push_data_o.delta       = signed'(in_data_i.raw_count - last_count_q);
    push_data_o.key_pressed = in_data_i.key_pressed;
    push_data_o.time_ms     = in_data_i.time_ms;
    push_data_o.take_steps  = in_data_i.take_steps;
    push_data_o.take_click  = in_data_i.take_click;
    push_data_o.take_long   = in_data_i.take_long;
  end

  always_comb begin
    primed_d     = primed_q;
    last_count_d = last_count_q;
    if (push_o) begin
      primed_d     = 1'b1;
      last_count_d = in_data_i.raw_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q     <= 1'b0;
      last_count_q <= '0;
    end else begin
      primed_q     <= primed_d;
      last_count_q <= last_count_d;
    end
  end

endmodule

// ===== rtl/edbe_back.sv =====
// ----------------------------------------------------------------------------
// edbe_back
// Folds counts into detent steps with a bit-serial divider, runs the button
// debounce and press timing, applies takes and holds the result register.
// ----------------------------------------------------------------------------
module edbe_back #(
  parameter int unsigned PENDING_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  edbe_pkg::cfg_t      cfg_i,
  input  logic                rec_valid_i,
  input  edbe_pkg::poll_t     rec_i,
  output logic                rec_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output edbe_pkg::out_item_t out_data_o
);
  import edbe_pkg::*;

  localparam int unsigned PW = PENDING_WIDTH;
  localparam int unsigned SW = 34;
  localparam logic signed [SW-1:0] PendMax =
    signed'(SW'((64'd1 << (PENDING_WIDTH - 1)) - 64'd1));
  localparam logic signed [SW-1:0] PendMin = -PendMax - 1;
  localparam logic [DivCntWidth-1:0] DivLast = DivCntWidth'(DivSteps - 1);

  back_state_e state_q, state_d;

  poll_t                  rec_q;
  logic [4:0]             rem_q;
  logic [31:0]            quot_q;
  logic [DivCntWidth-1:0] cnt_q;
  logic                   neg_q;
  logic signed [4:0]      residue_q;
  logic signed [PW-1:0]   pend_q;
  logic                   raw_q, stable_q;
  logic [31:0]            lct_q, press_q;
  logic                   clickp_q, longp_q, longd_q;
  logic                   out_valid_q;
  out_item_t              out_q;

  logic div_en, fold_en, fin_fire;

  logic [4:0]         cpd_eff;
  logic [3:0]         max_eff;
  logic signed [32:0] acc;
  logic [32:0]        acc_mag;
  logic [5:0]         rem_sh;
  logic               ge;
  logic [5:0]         rem_sub;
  logic signed [32:0] q_pos, q_s;
  logic signed [SW-1:0] sum;
  logic signed [PW-1:0] pend_fold;
  logic signed [4:0]    residue_fold;

  logic signed [PW-1:0] pend_base, pend_fin, m_w;
  logic signed [4:0]    deliv;
  logic                 raw_n, stable_n, clickp_n, longp_n, longd_n, clk_out, lng_out;
  logic [31:0]          lct_n, press_n, dt_lvl, dt_press, dt_long;
  logic                 rising;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (rec_valid_i) begin
          state_d = rec_i.first ? BK_FIN : BK_DIV;
        end
      end
      BK_DIV: begin
        if (cnt_q == DivLast) begin
          state_d = BK_FOLD;
        end
      end
      BK_FOLD: state_d = BK_FIN;
      BK_FIN: begin
        if (fin_fire) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    rec_pop_o = 1'b0;
    div_en    = 1'b0;
    fold_en   = 1'b0;
    fin_fire  = 1'b0;
    case (state_q)
      BK_IDLE: rec_pop_o = rec_valid_i;
      BK_DIV:  div_en = 1'b1;
      BK_FOLD: fold_en = 1'b1;
      BK_FIN:  fin_fire = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_comb begin
    if (cfg_i.counts_per_detent == 5'd0) begin
      cpd_eff = 5'd1;
    end else if (cfg_i.counts_per_detent > 5'd16) begin
      cpd_eff = 5'd16;
    end else begin
      cpd_eff = cfg_i.counts_per_detent;
    end
    max_eff = (cfg_i.max_steps_per_take == 4'd0) ? 4'd1 : cfg_i.max_steps_per_take;
  end

  // Divider load and step.
  always_comb begin
    acc     = 33'(residue_q) + 33'(rec_i.delta);
    acc_mag = acc[32] ? 33'(-acc) : 33'(acc);
    rem_sh  = {rem_q, quot_q[31]};
    ge      = (rem_sh >= {1'b0, cpd_eff});
    rem_sub = rem_sh - {1'b0, cpd_eff};
  end

  // Fold the quotient into the pending count.
  always_comb begin
    q_pos = signed'({1'b0, quot_q});
    q_s   = (neg_q ^ cfg_i.invert_direction) ? -q_pos : q_pos;
    sum   = SW'(pend_q) + SW'(q_s);
    if (sum > PendMax) begin
      pend_fold = PW'(PendMax);
    end else if (sum < PendMin) begin
      pend_fold = PW'(PendMin);
    end else begin
      pend_fold = PW'(sum);
    end
    residue_fold = neg_q ? -signed'(rem_q) : signed'(rem_q);
  end

  // Button timing and takes.
  always_comb begin
    raw_n    = raw_q;
    stable_n = stable_q;
    lct_n    = lct_q;
    press_n  = press_q;
    clickp_n = clickp_q;
    longp_n  = longp_q;
    longd_n  = longd_q;
    rising   = 1'b0;
    dt_lvl   = '0;
    dt_press = rec_q.time_ms - press_q;
    dt_long  = dt_press;
    if (rec_q.first) begin
      raw_n    = rec_q.key_pressed;
      stable_n = rec_q.key_pressed;
      lct_n    = rec_q.time_ms;
      clickp_n = 1'b0;
      longp_n  = 1'b0;
      longd_n  = 1'b0;
    end else begin
      if (rec_q.key_pressed != raw_q) begin
        raw_n = rec_q.key_pressed;
        lct_n = rec_q.time_ms;
      end else begin
        dt_lvl = rec_q.time_ms - lct_q;
      end
      if (dt_lvl >= 32'(cfg_i.debounce_ms) && stable_q != raw_n) begin
        stable_n = raw_n;
        if (raw_n) begin
          rising  = 1'b1;
          press_n = rec_q.time_ms;
          longd_n = 1'b0;
        end else if (!longd_q && dt_press < 32'(cfg_i.click_max_ms)) begin
          clickp_n = 1'b1;
        end
      end
      if (rising) begin
        dt_long = '0;
      end
      if (stable_n && !longd_n && dt_long >= 32'(cfg_i.long_press_ms)) begin
        longd_n  = 1'b1;
        longp_n  = 1'b1;
        clickp_n = 1'b0;
      end
    end

    pend_base = rec_q.first ? '0 : pend_q;
    m_w       = PW'(signed'({1'b0, max_eff}));
    pend_fin  = pend_base;
    deliv     = '0;
    if (rec_q.take_steps) begin
      if (pend_base > m_w) begin
        pend_fin = pend_base - m_w;
        deliv    = signed'({1'b0, max_eff});
      end else if (pend_base < -m_w) begin
        pend_fin = pend_base + m_w;
        deliv    = -signed'({1'b0, max_eff});
      end else begin
        pend_fin = '0;
        deliv    = pend_base[4:0];
      end
    end
    clk_out = 1'b0;
    lng_out = 1'b0;
    if (rec_q.take_click && clickp_n) begin
      clickp_n = 1'b0;
      clk_out  = 1'b1;
    end
    if (rec_q.take_long && longp_n) begin
      longp_n = 1'b0;
      lng_out = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      residue_q   <= '0;
      pend_q      <= '0;
      raw_q       <= 1'b0;
      stable_q    <= 1'b0;
      lct_q       <= '0;
      press_q     <= '0;
      clickp_q    <= 1'b0;
      longp_q     <= 1'b0;
      longd_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (rec_pop_o) begin
        cnt_q <= '0;
      end else if (div_en) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (fold_en) begin
        residue_q <= residue_fold;
        pend_q    <= pend_fold;
      end
      if (fin_fire) begin
        if (rec_q.first) begin
          residue_q <= '0;
        end
        pend_q      <= pend_fin;
        raw_q       <= raw_n;
        stable_q    <= stable_n;
        lct_q       <= lct_n;
        press_q     <= press_n;
        clickp_q    <= clickp_n;
        longp_q     <= longp_n;
        longd_q     <= longd_n;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      rec_q  <= rec_i;
      rem_q  <= '0;
      quot_q <= acc_mag[31:0];
      neg_q  <= acc[32];
    end else if (div_en) begin
      rem_q  <= ge ? rem_sub[4:0] : rem_sh[4:0];
      quot_q <= {quot_q[30:0], ge};
    end
    if (fin_fire) begin
      out_q.steps      <= deliv;
      out_q.click      <= clk_out;
      out_q.long_press <= lng_out;
      out_q.held       <= stable_n;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/encoder_detent_and_button_events_unit.sv =====
// ----------------------------------------------------------------------------
// encoder_detent_and_button_events_unit
// Rotary encoder detent folding with button debounce, click and long press.
// ----------------------------------------------------------------------------
// Each request on the input channel is one poll: the encoder counter, the
// button level, a millisecond time and three take flags. Every poll gives
// exactly one result request on the output channel with the delivered
// steps, the click and long press flags and the debounced button state.
// A front stage takes polls and turns the counter into a delta, a two-entry
// queue buffers them, and a back stage does the work one poll at a time.
// A normal poll runs the back stage's divide, fold and finish steps; the
// bit-serial divider folds counts into detents at one quotient bit per
// cycle; the first poll after reset only captures state and skips division.
// While a result waits in the output register the front keeps accepting
// polls until the queue is full, then input ready drops. The configuration
// port is always ready; registers should be written only while idle.
// Reset clears control state, loads the config defaults; the first poll primes.
// ----------------------------------------------------------------------------
module encoder_detent_and_button_events_unit #(
  parameter int unsigned PENDING_WIDTH = 16,
  parameter int unsigned QUEUE_DEPTH   = 2
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  edbe_pkg::in_item_t                     in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output edbe_pkg::out_item_t                    out_data_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [edbe_pkg::CfgIdxWidth-1:0]       cfg_index_i,
  input  logic [edbe_pkg::CfgDataWidth-1:0]      cfg_data_i
);
  import edbe_pkg::*;

  cfg_t  cfg_q, cfg_d;
  logic  q_push, q_full, q_pop, q_empty;
  poll_t q_wdata, q_rdata;
  logic [3:0] max_eff;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_COUNTS_PER_DETENT: cfg_d.counts_per_detent  = cfg_data_i[4:0];
        REG_INVERT_DIRECTION:  cfg_d.invert_direction   = cfg_data_i[0];
        REG_MAX_STEPS:         cfg_d.max_steps_per_take = cfg_data_i[3:0];
        REG_DEBOUNCE_MS:       cfg_d.debounce_ms        = cfg_data_i;
        REG_CLICK_MAX_MS:      cfg_d.click_max_ms       = cfg_data_i;
        REG_LONG_PRESS_MS:     cfg_d.long_press_ms      = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.counts_per_detent  <= RST_COUNTS_PER_DETENT;
      cfg_q.invert_direction   <= RST_INVERT_DIRECTION;
      cfg_q.max_steps_per_take <= RST_MAX_STEPS;
      cfg_q.debounce_ms        <= RST_DEBOUNCE_MS;
      cfg_q.click_max_ms       <= RST_CLICK_MAX_MS;
      cfg_q.long_press_ms      <= RST_LONG_PRESS_MS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  edbe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_o      (q_push),
    .push_data_o (q_wdata),
    .full_i      (q_full)
  );

  edbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .empty_o     (q_empty)
  );

  edbe_back #(
    .PENDING_WIDTH (PENDING_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .rec_valid_i (!q_empty),
    .rec_i       (q_rdata),
    .rec_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  assign max_eff = (cfg_q.max_steps_per_take == 4'd0) ? 4'd1 : cfg_q.max_steps_per_take;

  a_pop_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push && !q_pop |-> !q_full)
    else $error("queue pushed while full");

  a_steps_clipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(out_data_o.steps) <= $signed({1'b0, max_eff}) &&
                     $signed(out_data_o.steps) >= -$signed({1'b0, max_eff})))
    else $error("delivered steps exceed the per-take limit");

endmodule
